[design/tmf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_pkg
// Shared constants and types for the temporal median filter.
// ----------------------------------------------------------------------------
package tmf_pkg;
    localparam int CHANNELS_DEF    = 1024;
    localparam int MAX_WINDOW_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CH_BITS         = 10;
    localparam int WP_BITS         = 4;
    localparam logic [WP_BITS-1:0] WP_RESET = 4'd4;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture input transaction, start history read
        logic wr_hist;  // write new sample into its slot
        logic rd_step;  // present next history slot to the selector
        logic clr_cnt;  // clear rank counters
        logic acc;      // accumulate rank of current candidate
        logic finish;   // form median and load output register
    } tmf_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_busy;  // output register still holds a result
    } tmf_sts_t;
endpackage

[design/temporal_median_filter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temporal_median_filter_top
// Per-channel temporal median over successive scans.
// ----------------------------------------------------------------------------
// Input stream s_axis: tdata = {sample, channel}, tlast = last sample of scan.
// Output stream m_axis: tdata = {median_x2, channel}, tlast echoes the input.
// One transaction in gives one transaction out.
// Each item is handled by reading one history slot per cycle from the
// single port history memory and then ranking the window (count = samples
// in the window, up to MAX_WINDOW).
// One item is in flight; the next is accepted once the result has been
// moved to the output register. A stalled receiver holds the result and,
// once the sequencer finishes the next item, holds s_axis_tready low.
// Reset clears ring position, scan count, window_prev (to 4) and valids;
// the history memory is not cleared.
// ----------------------------------------------------------------------------
module temporal_median_filter_top
    import tmf_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [WP_BITS-1:0] cfg_wdata,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // [9:0] channel, [9+SAMPLE_BITS:10] sample, zero fill
    input  logic [((CH_BITS+SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic s_axis_tlast,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // [9:0] channel_out, [10+SAMPLE_BITS:10] median_x2, zero fill
    output logic [((CH_BITS+SAMPLE_BITS+8)/8)*8-1:0] m_axis_tdata,
    output logic m_axis_tlast
);
    localparam int OW = ((CH_BITS + SAMPLE_BITS + 8) / 8) * 8;
    tmf_cmd_t cmd;
    tmf_sts_t sts;
    logic [WP_BITS-1:0] wp_reg;
    logic [CH_BITS-1:0] och;
    logic [SAMPLE_BITS:0] omed;
    logic [$clog2(MAX_WINDOW+1)-1:0] cnt;
    logic in_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= WP_RESET;
        end
        else if (cfg_we)
        begin
            wp_reg <= cfg_wdata;
        end
    end

    assign in_fire = s_axis_tvalid && s_axis_tready;

    tmf_ctrl #(.MAX_WINDOW(MAX_WINDOW)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .sts(sts), .count(cnt),
        .in_ready(s_axis_tready), .cmd(cmd)
    );

    tmf_datapath #(.CHANNELS(CHANNELS), .MAX_WINDOW(MAX_WINDOW),
                   .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .window_prev(wp_reg),
        .in_channel(s_axis_tdata[CH_BITS-1:0]),
        .in_sample(s_axis_tdata[CH_BITS+SAMPLE_BITS-1:CH_BITS]),
        .in_last(s_axis_tlast), .out_take(m_axis_tready),
        .out_valid(m_axis_tvalid), .out_channel(och), .out_median(omed),
        .out_last(m_axis_tlast), .count_o(cnt)
    );

    assign m_axis_tdata = OW'({omed, och});

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("input accepted while busy");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwritten");
`endif
endmodule

[design/tmf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module tmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[design/tmf_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_datapath
// History memory, window buffer, rank counting and output register.
// ----------------------------------------------------------------------------
module tmf_datapath
    import tmf_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tmf_cmd_t               cmd,
    output tmf_sts_t               sts,
    input  logic [WP_BITS-1:0]     window_prev,
    input  logic [CH_BITS-1:0]     in_channel,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  logic                   in_last,
    input  logic                   out_take,
    output logic                   out_valid,
    output logic [CH_BITS-1:0]     out_channel,
    output logic [SAMPLE_BITS:0]   out_median,
    output logic                   out_last,
    output logic [$clog2(MAX_WINDOW+1)-1:0] count_o
);
    localparam int PB = $clog2(MAX_WINDOW);
    localparam int CB = $clog2(MAX_WINDOW + 1);
    localparam int AB = $clog2(CHANNELS * MAX_WINDOW);
    localparam int CHB = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [CHB-1:0]         ch_reg;
    logic [CH_BITS-1:0]     chraw_reg;
    logic [SAMPLE_BITS-1:0] smp_reg;
    logic                   last_reg;
    logic [PB-1:0]          ring_reg, rp_reg;
    logic [CB-1:0]          seen_reg, count_reg;
    logic [SAMPLE_BITS-1:0] rdata;
    logic [SAMPLE_BITS-1:0] win_reg [MAX_WINDOW];
    logic [CB-1:0]          lt_reg [MAX_WINDOW];
    logic [CB-1:0]          le_reg [MAX_WINDOW];
    logic [CB-1:0]          fill_reg;
    logic [CB-1:0]          wlen;
    logic [CB-1:0]          cnt_next;
    logic [AB-1:0]          addr;
    logic                   ovalid_reg;
    logic [SAMPLE_BITS-1:0] cand;
    logic [SAMPLE_BITS-1:0] lo_v, hi_v;
    logic [CB-1:0]          k_lo, k_hi;
    logic [CH_BITS-1:0]     ch_mod;
    logic [MAX_WINDOW-1:0]  lt_hit, le_hit;

    // window length, zero treated as one, capped at storage
    always_comb
    begin
        wlen = CB'(((window_prev == '0) ? 1 : int'(window_prev)) + 1);
        if (wlen > CB'(MAX_WINDOW))
        begin
            wlen = CB'(MAX_WINDOW);
        end
        cnt_next = seen_reg + CB'(1);
        if (cnt_next > wlen)
        begin
            cnt_next = wlen;
        end
    end

    // channel folded onto the channel count by constant compare and subtract
    always_comb
    begin
        ch_mod = in_channel;
        for (int s = CH_BITS - 1; s >= 0; s--)
        begin
            if ((CHANNELS << s) < (1 << CH_BITS))
            begin
                if (ch_mod >= CH_BITS'(CHANNELS << s))
                begin
                    ch_mod = ch_mod - CH_BITS'(CHANNELS << s);
                end
            end
        end
    end

    // input capture and ring state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg   <= '0;
            seen_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                ovalid_reg <= 1'b1;
                if (last_reg)
                begin
                    ring_reg <= (int'(ring_reg) + 1 >= MAX_WINDOW) ? '0 : ring_reg + PB'(1);
                    if (int'(seen_reg) < MAX_WINDOW)
                    begin
                        seen_reg <= seen_reg + CB'(1);
                    end
                end
            end
            else if (out_take)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            chraw_reg <= ch_mod;
            ch_reg    <= CHB'(ch_mod);
            smp_reg   <= in_sample;
            last_reg  <= in_last;
            count_reg <= cnt_next;
            rp_reg    <= ring_reg;
            fill_reg  <= '0;
        end
        else if (cmd.rd_step)
        begin
            rp_reg <= (rp_reg == '0) ? PB'(MAX_WINDOW - 1) : rp_reg - PB'(1);
        end
        // collect window values as they return from the memory
        if (cmd.acc)
        begin
            win_reg[fill_reg[PB-1:0]] <= (fill_reg == '0) ? smp_reg : rdata;
            fill_reg <= fill_reg + CB'(1);
        end
    end

    assign addr = AB'(int'(ch_reg) * MAX_WINDOW + int'(rp_reg));

    tmf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(CHANNELS * MAX_WINDOW)) u_ram (
        .clk   (clk),
        .we    (cmd.wr_hist),
        .addr  (addr),
        .wdata (smp_reg),
        .rdata (rdata)
    );

    // rank counting: each entry compared against the newly arrived value
    assign cand = (fill_reg == '0) ? smp_reg : rdata;

    // earlier entries below / not above the new value
    always_comb
    begin
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            lt_hit[j] = (CB'(j) < fill_reg) && (win_reg[j] < cand);
            le_hit[j] = (CB'(j) < fill_reg) && (win_reg[j] <= cand);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            if (cmd.clr_cnt)
            begin
                lt_reg[i] <= '0;
                le_reg[i] <= '0;
            end
            else if (cmd.acc && CB'(i) < fill_reg)
            begin
                if (cand < win_reg[i])
                begin
                    lt_reg[i] <= lt_reg[i] + CB'(1);
                    le_reg[i] <= le_reg[i] + CB'(1);
                end
                else if (cand == win_reg[i])
                begin
                    le_reg[i] <= le_reg[i] + CB'(1);
                end
            end
            else if (cmd.acc && CB'(i) == fill_reg)
            begin
                // new entry ranks against all earlier entries at once
                lt_reg[i] <= CB'($countones(lt_hit));
                le_reg[i] <= CB'($countones(le_hit)) + CB'(1);
            end
        end
    end

    // pick the two middle entries by rank
    always_comb
    begin
        k_lo = CB'((int'(count_reg) - 1) / 2);
        k_hi = CB'(int'(count_reg) / 2);
        lo_v = '0;
        hi_v = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            if (CB'(i) < count_reg && lt_reg[i] <= k_lo && k_lo < le_reg[i])
            begin
                lo_v = win_reg[i];
            end
            if (CB'(i) < count_reg && lt_reg[i] <= k_hi && k_hi < le_reg[i])
            begin
                hi_v = win_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_channel <= chraw_reg;
            out_last    <= last_reg;
            out_median  <= (SAMPLE_BITS+1)'(lo_v) + (SAMPLE_BITS+1)'(hi_v);
        end
    end

    assign out_valid    = ovalid_reg;
    assign sts.out_busy = ovalid_reg;
    assign count_o      = count_reg;
endmodule

[design/tmf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_ctrl
// Sequencer: write new sample, read back the window, then rank and emit.
// ----------------------------------------------------------------------------
module tmf_ctrl
    import tmf_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_fire,
    input  tmf_sts_t sts,
    input  logic [$clog2(MAX_WINDOW+1)-1:0] count,
    output logic     in_ready,
    output tmf_cmd_t cmd
);
    localparam int CB = $clog2(MAX_WINDOW + 1);
    typedef enum logic [2:0] {S_IDLE, S_WRITE, S_READ, S_COLLECT, S_FINISH, S_HOLD} state_t;
    state_t        state_reg;
    logic [CB-1:0] n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:    if (in_fire) state_reg <= S_WRITE;
                S_WRITE:
                begin
                    n_reg     <= CB'(1);
                    state_reg <= S_READ;
                end
                S_READ:    state_reg <= S_COLLECT;
                S_COLLECT:
                begin
                    n_reg <= n_reg + CB'(1);
                    if (n_reg >= count)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:  state_reg <= sts.out_busy ? S_FINISH : S_HOLD;
                S_HOLD:    state_reg <= S_IDLE;
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

    // command decode; each memory read is issued in the cycle before its data is collected
    always_comb
    begin
        cmd         = '0;
        cmd.load    = in_fire;
        cmd.wr_hist = (state_reg == S_WRITE);
        cmd.clr_cnt = in_fire;
        cmd.rd_step = (state_reg == S_WRITE) || (state_reg == S_READ) ||
                      (state_reg == S_COLLECT);
        cmd.acc     = (state_reg == S_READ) ||
                      (state_reg == S_COLLECT && n_reg < count);
        cmd.finish  = (state_reg == S_FINISH) && !sts.out_busy;
    end

    assign in_ready = (state_reg == S_IDLE);
endmodule
